// ===== design/baf_pkg.sv =====
`default_nettype none
package baf_pkg;

   localparam int COORD_BITS_DEFAULT = 32;

   localparam logic [30:0] LOW_RESET  = 31'd0;
   localparam logic [30:0] HIGH_RESET = 31'd6553600;
   localparam logic [31:0] MAG_RESET  = 32'd65536;

   // one result bit per stage in each iterative unit
   localparam int SQRT_STAGES = 32;
   localparam int DIV1_STAGES = 32;
   localparam int DIV2_STAGES = 33;

   typedef enum logic [1:0] {
      REG_LOW  = 2'd0,
      REG_HIGH = 2'd1,
      REG_MAG  = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [33:0] rem;
      logic [31:0] root;
   } sqrt_st_type;

   typedef struct packed {
      logic [31:0] rem;
      logic        qbit;
   } div_st_type;

   // one digit of the integer square root, two radicand bits per step
   function automatic sqrt_st_type sqrt_step(sqrt_st_type s, logic [1:0] bits);
      logic [35:0] r_in;
      logic [35:0] trial;
      sqrt_st_type o;
      r_in  = {s.rem, bits};
      trial = {2'b00, s.root, 2'b01};
      if (r_in >= trial) begin
         o.rem  = 34'(r_in - trial);
         o.root = {s.root[30:0], 1'b1};
      end else begin
         o.rem  = r_in[33:0];
         o.root = {s.root[30:0], 1'b0};
      end
      return o;
   endfunction

   // one restoring division step; rem stays below the divisor
   function automatic div_st_type div_step(logic [31:0] rem, logic bit_in, logic [31:0] dvs);
      logic [32:0] r_in;
      div_st_type  o;
      r_in = {rem, bit_in};
      if (r_in >= {1'b0, dvs}) begin
         o.rem  = 32'(r_in - {1'b0, dvs});
         o.qbit = 1'b1;
      end else begin
         o.rem  = r_in[31:0];
         o.qbit = 1'b0;
      end
      return o;
   endfunction

endpackage
`default_nettype wire

// ===== design/banded_attraction_force_top.sv =====
`default_nettype none
// Force between a particle and another point, signed fixed point in 3D. The distance is the
// floor of the Euclidean norm; inside the band [low, high] the force is the unit direction
// scaled by a magnitude falling linearly from signed_magnitude at low to zero at high, with
// both quotients rounded half away from zero and each component saturated to 32 bits. One item
// is taken every cycle while the pipe is not stalled; each result passes through the
// square-root pipe (32 stages) and the two dividers (32 and 33 stages), one result bit per
// stage. A held result stalls the whole pipe, so nothing is lost. The user must write bounds
// and magnitude (APB 0x0, 0x4, 0x8) only while no item is in flight; the block does not check.
module banded_attraction_force_top
   import baf_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire signed [COORD_BITS-1:0]  req_self_x,
   input  wire signed [COORD_BITS-1:0]  req_self_y,
   input  wire signed [COORD_BITS-1:0]  req_self_z,
   input  wire signed [COORD_BITS-1:0]  req_other_x,
   input  wire signed [COORD_BITS-1:0]  req_other_y,
   input  wire signed [COORD_BITS-1:0]  req_other_z,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic signed [31:0]           rsp_force_x,
   output logic signed [31:0]           rsp_force_y,
   output logic signed [31:0]           rsp_force_z,
   output logic                         rsp_in_band,
   input  wire                          psel,
   input  wire                          penable,
   input  wire                          pwrite,
   input  wire [3:0]                    paddr,
   input  wire [31:0]                   pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   logic [30:0] csr_low_ff;
   logic [30:0] csr_high_ff;
   logic [31:0] csr_mag_ff;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_low_ff  <= LOW_RESET;
         csr_high_ff <= HIGH_RESET;
         csr_mag_ff  <= MAG_RESET;
      end else if (psel && penable && pwrite) begin
         case (reg_index_type'(paddr[3:2]))
            REG_LOW:  csr_low_ff  <= pwdata[30:0];
            REG_HIGH: csr_high_ff <= pwdata[30:0];
            REG_MAG:  csr_mag_ff  <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(paddr[3:2]))
         REG_LOW:  prdata = {1'b0, csr_low_ff};
         REG_HIGH: prdata = {1'b0, csr_high_ff};
         REG_MAG:  prdata = csr_mag_ff;
         default:  prdata = 32'd0;
      endcase
   end

   // derived from registers that the user must hold still while items are in flight (not enforced)
   logic [31:0] mag_abs;
   logic        mag_neg;
   logic [30:0] den;
   logic        bounds_eq;
   assign mag_neg   = csr_mag_ff[31];
   assign mag_abs   = mag_neg ? 32'(-csr_mag_ff) : csr_mag_ff;
   assign den       = 31'(csr_high_ff - csr_low_ff);
   assign bounds_eq = (csr_high_ff == csr_low_ff);

   logic adv;
   logic out_v_ff;
   assign adv       = !out_v_ff || rsp_ready;
   assign req_ready = adv;

   // stage A: differences and magnitudes
   logic signed [COORD_BITS:0] d_in [3];
   logic        [COORD_BITS:0] ad_in [3];
   logic                       far_in;
   always_comb begin
      d_in[0] = (COORD_BITS+1)'(req_other_x) - (COORD_BITS+1)'(req_self_x);
      d_in[1] = (COORD_BITS+1)'(req_other_y) - (COORD_BITS+1)'(req_self_y);
      d_in[2] = (COORD_BITS+1)'(req_other_z) - (COORD_BITS+1)'(req_self_z);
      far_in  = 1'b0;
      for (int i = 0; i < 3; i++) begin
         ad_in[i] = d_in[i][COORD_BITS] ? (COORD_BITS+1)'(-d_in[i])
                                        : (COORD_BITS+1)'(d_in[i]);
         if (64'(ad_in[i]) > 64'(csr_high_ff))
            far_in = 1'b1;
      end
   end

   logic        a_v_ff, b_v_ff, c_v_ff;
   logic [30:0] a_a_ff [3];
   logic [30:0] b_a_ff [3];
   logic [30:0] c_a_ff [3];
   logic        a_sg_ff [3];
   logic        b_sg_ff [3];
   logic        c_sg_ff [3];
   logic        a_far_ff, b_far_ff, c_far_ff;
   logic [61:0] b_sq_ff [3];
   logic [63:0] c_sum_ff;

   // square-root pipe
   logic        s_v_ff   [SQRT_STAGES];
   sqrt_st_type s_st_ff  [SQRT_STAGES];
   logic [63:0] s_rad_ff [SQRT_STAGES];
   logic [30:0] s_a_ff   [SQRT_STAGES][3];
   logic        s_sg_ff  [SQRT_STAGES][3];
   logic        s_far_ff [SQRT_STAGES];

   // stage D: band test; stage E: falloff numerator
   logic        d_v_ff, e_v_ff;
   logic [31:0] d_dist_ff, e_dist_ff;
   logic        d_inb_ff, e_inb_ff, d_zero_ff, e_zero_ff;
   logic [30:0] d_hd_ff;
   logic [30:0] d_a_ff [3];
   logic [30:0] e_a_ff [3];
   logic        d_sg_ff [3];
   logic        e_sg_ff [3];
   logic [63:0] e_num_ff;

   // first divider: falloff magnitude
   logic        q_v_ff    [DIV1_STAGES];
   logic [31:0] q_rem_ff  [DIV1_STAGES];
   logic [31:0] q_x_ff    [DIV1_STAGES];
   logic [31:0] q_q_ff    [DIV1_STAGES];
   logic [31:0] q_dist_ff [DIV1_STAGES];
   logic        q_inb_ff  [DIV1_STAGES];
   logic        q_zero_ff [DIV1_STAGES];
   logic [30:0] q_a_ff    [DIV1_STAGES][3];
   logic        q_sg_ff   [DIV1_STAGES][3];

   // stage F: chosen magnitude; stage G: component numerators
   logic        f_v_ff, g_v_ff;
   logic [31:0] f_m_ff;
   logic [31:0] f_dist_ff, g_dist_ff;
   logic        f_inb_ff, g_inb_ff, f_zero_ff, g_zero_ff;
   logic [30:0] f_a_ff [3];
   logic        f_sg_ff [3];
   logic        g_sg_ff [3];
   logic [63:0] g_num_ff [3];

   // second divider: three lanes, one per axis
   logic        r_v_ff    [DIV2_STAGES];
   logic [31:0] r_rem_ff  [DIV2_STAGES][3];
   logic [32:0] r_x_ff    [DIV2_STAGES][3];
   logic [32:0] r_q_ff    [DIV2_STAGES][3];
   logic [31:0] r_dist_ff [DIV2_STAGES];
   logic        r_inb_ff  [DIV2_STAGES];
   logic        r_zero_ff [DIV2_STAGES];
   logic        r_sg_ff   [DIV2_STAGES][3];

   logic [31:0] force_in [3];
   logic [31:0] force_ff [3];
   logic        inb_out_ff;

   localparam int SL = SQRT_STAGES - 1;
   localparam int QL = DIV1_STAGES - 1;
   localparam int RL = DIV2_STAGES - 1;

   always_comb begin
      logic [32:0] q;
      logic        neg;
      for (int i = 0; i < 3; i++) begin
         q   = r_q_ff[RL][i];
         neg = (r_sg_ff[RL][i] != mag_neg) && (q != 33'd0);
         if (!r_inb_ff[RL] || r_zero_ff[RL])
            force_in[i] = 32'd0;
         else if (neg)
            force_in[i] = (q > 33'h080000000) ? 32'h80000000 : 32'(-q);
         else
            force_in[i] = (q > 33'h07FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff   <= 1'b0;
         b_v_ff   <= 1'b0;
         c_v_ff   <= 1'b0;
         d_v_ff   <= 1'b0;
         e_v_ff   <= 1'b0;
         f_v_ff   <= 1'b0;
         g_v_ff   <= 1'b0;
         out_v_ff <= 1'b0;
         for (int s = 0; s < SQRT_STAGES; s++) s_v_ff[s] <= 1'b0;
         for (int s = 0; s < DIV1_STAGES; s++) q_v_ff[s] <= 1'b0;
         for (int s = 0; s < DIV2_STAGES; s++) r_v_ff[s] <= 1'b0;
      end else if (adv) begin
         a_v_ff    <= req_valid;
         b_v_ff    <= a_v_ff;
         c_v_ff    <= b_v_ff;
         s_v_ff[0] <= c_v_ff;
         for (int s = 1; s < SQRT_STAGES; s++) s_v_ff[s] <= s_v_ff[s-1];
         d_v_ff    <= s_v_ff[SL];
         e_v_ff    <= d_v_ff;
         q_v_ff[0] <= e_v_ff;
         for (int s = 1; s < DIV1_STAGES; s++) q_v_ff[s] <= q_v_ff[s-1];
         f_v_ff    <= q_v_ff[QL];
         g_v_ff    <= f_v_ff;
         r_v_ff[0] <= g_v_ff;
         for (int s = 1; s < DIV2_STAGES; s++) r_v_ff[s] <= r_v_ff[s-1];
         out_v_ff  <= r_v_ff[RL];
      end
   end

   // payload
   always_ff @(posedge clock) begin
      sqrt_st_type st0;
      div_st_type  dv;
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            a_a_ff[i]  <= 31'(ad_in[i]);
            a_sg_ff[i] <= d_in[i][COORD_BITS];
            b_a_ff[i]  <= a_a_ff[i];
            b_sg_ff[i] <= a_sg_ff[i];
            b_sq_ff[i] <= 62'(a_a_ff[i]) * 62'(a_a_ff[i]);
            c_a_ff[i]  <= b_a_ff[i];
            c_sg_ff[i] <= b_sg_ff[i];
         end
         a_far_ff <= far_in;
         b_far_ff <= a_far_ff;
         c_far_ff <= b_far_ff;
         c_sum_ff <= 64'(b_sq_ff[0]) + 64'(b_sq_ff[1]) + 64'(b_sq_ff[2]);

         // square root
         st0.rem  = 34'd0;
         st0.root = 32'd0;
         s_st_ff[0]  <= sqrt_step(st0, c_sum_ff[63:62]);
         s_rad_ff[0] <= {c_sum_ff[61:0], 2'b00};
         s_far_ff[0] <= c_far_ff;
         for (int i = 0; i < 3; i++) begin
            s_a_ff[0][i]  <= c_a_ff[i];
            s_sg_ff[0][i] <= c_sg_ff[i];
         end
         for (int s = 1; s < SQRT_STAGES; s++) begin
            s_st_ff[s]  <= sqrt_step(s_st_ff[s-1], s_rad_ff[s-1][63:62]);
            s_rad_ff[s] <= {s_rad_ff[s-1][61:0], 2'b00};
            s_far_ff[s] <= s_far_ff[s-1];
            for (int i = 0; i < 3; i++) begin
               s_a_ff[s][i]  <= s_a_ff[s-1][i];
               s_sg_ff[s][i] <= s_sg_ff[s-1][i];
            end
         end

         // band test
         d_dist_ff <= s_st_ff[SL].root;
         d_inb_ff  <= !s_far_ff[SL] && (s_st_ff[SL].root >= 32'(csr_low_ff))
                      && (s_st_ff[SL].root <= 32'(csr_high_ff));
         d_zero_ff <= (s_st_ff[SL].root == 32'd0);
         d_hd_ff   <= 31'(32'(csr_high_ff) - s_st_ff[SL].root);
         for (int i = 0; i < 3; i++) begin
            d_a_ff[i]  <= s_a_ff[SL][i];
            d_sg_ff[i] <= s_sg_ff[SL][i];
            e_a_ff[i]  <= d_a_ff[i];
            e_sg_ff[i] <= d_sg_ff[i];
         end
         e_dist_ff <= d_dist_ff;
         e_inb_ff  <= d_inb_ff;
         e_zero_ff <= d_zero_ff;
         e_num_ff  <= 64'(64'(mag_abs) * 64'(d_hd_ff)) + 64'(den >> 1);

         // falloff divide by the band width
         dv = div_step(e_num_ff[63:32], e_num_ff[31], 32'(den));
         q_rem_ff[0]  <= dv.rem;
         q_q_ff[0]    <= {31'd0, dv.qbit};
         q_x_ff[0]    <= {e_num_ff[30:0], 1'b0};
         q_dist_ff[0] <= e_dist_ff;
         q_inb_ff[0]  <= e_inb_ff;
         q_zero_ff[0] <= e_zero_ff;
         for (int i = 0; i < 3; i++) begin
            q_a_ff[0][i]  <= e_a_ff[i];
            q_sg_ff[0][i] <= e_sg_ff[i];
         end
         for (int s = 1; s < DIV1_STAGES; s++) begin
            dv = div_step(q_rem_ff[s-1], q_x_ff[s-1][31], 32'(den));
            q_rem_ff[s]  <= dv.rem;
            q_q_ff[s]    <= {q_q_ff[s-1][30:0], dv.qbit};
            q_x_ff[s]    <= {q_x_ff[s-1][30:0], 1'b0};
            q_dist_ff[s] <= q_dist_ff[s-1];
            q_inb_ff[s]  <= q_inb_ff[s-1];
            q_zero_ff[s] <= q_zero_ff[s-1];
            for (int i = 0; i < 3; i++) begin
               q_a_ff[s][i]  <= q_a_ff[s-1][i];
               q_sg_ff[s][i] <= q_sg_ff[s-1][i];
            end
         end

         // equal bounds take full strength
         f_m_ff    <= bounds_eq ? mag_abs : q_q_ff[QL];
         f_dist_ff <= q_dist_ff[QL];
         f_inb_ff  <= q_inb_ff[QL];
         f_zero_ff <= q_zero_ff[QL];
         for (int i = 0; i < 3; i++) begin
            f_a_ff[i]   <= q_a_ff[QL][i];
            f_sg_ff[i]  <= q_sg_ff[QL][i];
            g_sg_ff[i]  <= f_sg_ff[i];
            g_num_ff[i] <= 64'(64'(f_a_ff[i]) * 64'(f_m_ff)) + 64'(f_dist_ff >> 1);
         end
         g_dist_ff <= f_dist_ff;
         g_inb_ff  <= f_inb_ff;
         g_zero_ff <= f_zero_ff;

         // component divide by the distance
         for (int i = 0; i < 3; i++) begin
            dv = div_step(32'(g_num_ff[i][63:33]), g_num_ff[i][32], g_dist_ff);
            r_rem_ff[0][i] <= dv.rem;
            r_q_ff[0][i]   <= {32'd0, dv.qbit};
            r_x_ff[0][i]   <= {g_num_ff[i][31:0], 1'b0};
            r_sg_ff[0][i]  <= g_sg_ff[i];
         end
         r_dist_ff[0] <= g_dist_ff;
         r_inb_ff[0]  <= g_inb_ff;
         r_zero_ff[0] <= g_zero_ff;
         for (int s = 1; s < DIV2_STAGES; s++) begin
            for (int i = 0; i < 3; i++) begin
               dv = div_step(r_rem_ff[s-1][i], r_x_ff[s-1][i][32], r_dist_ff[s-1]);
               r_rem_ff[s][i] <= dv.rem;
               r_q_ff[s][i]   <= {r_q_ff[s-1][i][31:0], dv.qbit};
               r_x_ff[s][i]   <= {r_x_ff[s-1][i][31:0], 1'b0};
               r_sg_ff[s][i]  <= r_sg_ff[s-1][i];
            end
            r_dist_ff[s] <= r_dist_ff[s-1];
            r_inb_ff[s]  <= r_inb_ff[s-1];
            r_zero_ff[s] <= r_zero_ff[s-1];
         end

         for (int i = 0; i < 3; i++) force_ff[i] <= force_in[i];
         inb_out_ff <= r_inb_ff[RL];
      end
   end

   assign rsp_valid   = out_v_ff;
   assign rsp_force_x = force_ff[0];
   assign rsp_force_y = force_ff[1];
   assign rsp_force_z = force_ff[2];
   assign rsp_in_band = inb_out_ff;

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
module tb;
   import baf_pkg::*;

   typedef struct {
      logic signed [31:0] sx, sy, sz, ox, oy, oz;
   } pair_type;

   typedef struct {
      logic signed [31:0] fx, fy, fz;
      logic               in_band;
   } force_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_self_x = '0, req_self_y = '0, req_self_z = '0;
   logic signed [31:0] req_other_x = '0, req_other_y = '0, req_other_z = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_force_x, rsp_force_y, rsp_force_z;
   logic               rsp_in_band;
   logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [3:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   banded_attraction_force_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_self_x(req_self_x), .req_self_y(req_self_y), .req_self_z(req_self_z),
      .req_other_x(req_other_x), .req_other_y(req_other_y), .req_other_z(req_other_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_force_x(rsp_force_x), .rsp_force_y(rsp_force_y), .rsp_force_z(rsp_force_z),
      .rsp_in_band(rsp_in_band),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #10 clock = ~clock;

   // shadow of the band and magnitude registers
   longint unsigned band_low  = LOW_RESET;
   longint unsigned band_high = HIGH_RESET;
   longint          peak_mag  = $signed(MAG_RESET);

   pair_type  pair_queue[$];
   force_type force_queue[$];
   pair_type  cur_pair;
   int        mismatches = 0;
   int        checked = 0;
   int        in_band_seen = 0;
   int        phases_run = 0;

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r, t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   function automatic logic [31:0] clamp32(bit neg, longint unsigned m);
      if (neg) begin
         if (m > 64'h8000_0000) m = 64'h8000_0000;
         return 32'(64'd0 - m);
      end
      if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
      return 32'(m);
   endfunction

   function automatic force_type predict_force(pair_type p);
      force_type       f;
      longint          d[3];
      longint unsigned a[3];
      longint unsigned sum, norm, meff, mabs, den, q;
      bit              far, mneg, neg;
      d[0] = longint'(p.ox) - longint'(p.sx);
      d[1] = longint'(p.oy) - longint'(p.sy);
      d[2] = longint'(p.oz) - longint'(p.sz);
      f = '{fx: '0, fy: '0, fz: '0, in_band: 1'b0};
      far = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = d[i] < 0 ? -d[i] : d[i];
         if (a[i] > band_high) far = 1;
      end
      if (far) return f;
      for (int i = 0; i < 3; i++) sum += a[i] * a[i];
      norm = root_floor(sum);
      if (norm < band_low || norm > band_high) return f;
      f.in_band = 1'b1;
      if (norm == 0) return f;
      mneg = peak_mag < 0;
      mabs = mneg ? -peak_mag : peak_mag;
      if (band_high == band_low) begin
         meff = mabs;
      end else begin
         den = band_high - band_low;
         meff = (mabs * (band_high - norm) + den / 2) / den;
      end
      for (int i = 0; i < 3; i++) begin
         q = (a[i] * meff + norm / 2) / norm;
         neg = (d[i] < 0) != mneg;
         case (i)
            0: f.fx = clamp32(neg && q != 0, q);
            1: f.fy = clamp32(neg && q != 0, q);
            default: f.fz = clamp32(neg && q != 0, q);
         endcase
      end
      return f;
   endfunction

   // driver: bursts of items separated by random gaps
   int burst_left = 4;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) force_queue.push_back(predict_force(cur_pair));
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               req_valid <= 1'b0;
            end else if (pair_queue.size() > 0) begin
               cur_pair = pair_queue.pop_front();
               req_self_x  <= cur_pair.sx;
               req_self_y  <= cur_pair.sy;
               req_self_z  <= cur_pair.sz;
               req_other_x <= cur_pair.ox;
               req_other_y <= cur_pair.oy;
               req_other_z <= cur_pair.oz;
               req_valid <= 1'b1;
               burst_left = burst_left - 1;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stalls follow a randomly redrawn pattern
   logic [15:0] stall_pat = 16'hFFFF;
   int          pat_cnt = 0;
   always @(posedge clock) begin
      if (pat_cnt % 64 == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pat = 16'hFFFF;
            1: stall_pat = 16'h0001;
            default: stall_pat = 16'($urandom);
         endcase
      end
      pat_cnt = pat_cnt + 1;
      rsp_ready <= reset ? 1'b0 : stall_pat[pat_cnt % 16];
   end

   // monitor
   always @(posedge clock) begin
      force_type exp_f;
      if (!reset && rsp_valid && rsp_ready) begin
         if (force_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item at %0t", $realtime);
         end else begin
            exp_f = force_queue.pop_front();
            checked++;
            if (exp_f.in_band) in_band_seen++;
            if (rsp_force_x !== exp_f.fx || rsp_force_y !== exp_f.fy ||
                rsp_force_z !== exp_f.fz || rsp_in_band !== exp_f.in_band) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %0d %0d %0d %0b got %0d %0d %0d %0b",
                           exp_f.fx, exp_f.fy, exp_f.fz, exp_f.in_band,
                           rsp_force_x, rsp_force_y, rsp_force_z, rsp_in_band);
            end
         end
      end
   end

   task automatic wait_idle();
      while (pair_queue.size() != 0 || req_valid || force_queue.size() != 0)
         @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [31:0] v);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_LOW:  band_low = v[30:0];
         REG_HIGH: band_high = v[30:0];
         default:  peak_mag = longint'($signed(v));
      endcase
   endtask

   task automatic set_band(logic [31:0] lo, logic [31:0] hi, logic [31:0] mag);
      wait_idle();
      csr_write(REG_LOW, lo);
      csr_write(REG_HIGH, hi);
      csr_write(REG_MAG, mag);
      phases_run++;
   endtask

   task automatic add_pair(logic [31:0] sx, sy, sz, ox, oy, oz);
      pair_type p;
      p = '{sx: sx, sy: sy, sz: sz, ox: ox, oy: oy, oz: oz};
      pair_queue.push_back(p);
   endtask

   function automatic logic [31:0] near_offset(longint unsigned span);
      longint unsigned o;
      o = span == 0 ? 0 : ({$urandom, $urandom} % (span + 1));
      return $urandom_range(0, 1) ? 32'(64'd0 - o) : 32'(o);
   endfunction

   task automatic add_random(int n);
      pair_type        p;
      longint unsigned span;
      for (int k = 0; k < n; k++) begin
         p.sx = $urandom;
         p.sy = $urandom;
         p.sz = $urandom;
         if ($urandom_range(0, 9) < 7) begin
            span = (band_high > band_low ? band_high : band_low) >> $urandom_range(0, 2);
            p.ox = p.sx + near_offset(span);
            p.oy = p.sy + near_offset(span);
            p.oz = p.sz + near_offset(span);
            if ($urandom_range(0, 19) == 0) p.ox = p.sx;
         end else begin
            p.ox = $urandom;
            p.oy = $urandom;
            p.oz = $urandom;
         end
         pair_queue.push_back(p);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset band: zero distance, bounds hit exactly, far points, extremes
      add_pair(0, 0, 0, 0, 0, 0);
      add_pair(32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0, 0);
      add_pair(0, 0, 0, 32'h0001_0000, 0, 0);
      add_pair(0, 0, 0, 0, 32'h0064_0000, 0);
      add_pair(0, 0, 0, 0, 0, 32'hFF9C_0000);
      add_pair(0, 0, 0, 32'h0064_0001, 0, 0);
      add_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_pair(32'h0030_0000, 32'h0030_0000, 32'h0030_0000, 0, 0, 0);
      add_pair(32'hFFFF_FFFF, 32'h1234_5678, 32'h8765_4321,
               32'h0000_0001, 32'h1238_0000, 32'h8760_0000);
      add_random(60);

      // equal bounds with the most negative peak: clamp on a negative axis
      set_band(32'h0001_0000, 32'h0001_0000, 32'h8000_0000);
      add_pair(32'h0001_0000, 0, 0, 0, 0, 0);
      add_pair(0, 0, 0, 32'h0001_0000, 0, 0);
      add_pair(0, 0, 0, 0, 32'hFFFF_0000, 0);
      add_pair(0, 0, 0, 0, 0, 32'h0001_0001);
      add_pair(0, 0, 0, 0, 0, 0);
      add_random(60);

      // widest band, strongest attraction
      set_band(32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_pair(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0);
      add_pair(32'h4000_0000, 0, 0, 32'hC000_0000, 0, 0);
      add_pair(0, 0, 0, 32'h7FFF_FFFF, 0, 0);
      add_random(90);

      // bounds reversed: never in band
      set_band(32'h0050_0000, 32'h0010_0000, 32'h0002_0000);
      add_pair(0, 0, 0, 32'h0030_0000, 0, 0);
      add_random(60);

      // narrow band, repulsion
      set_band(32'h0000_8000, 32'h0004_0000, 32'hFFFC_0000);
      add_random(100);

      // low bound written with its top bit set, which the register drops: equal bounds, small magnitude
      set_band(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0003);
      add_random(20);
      set_band(32'h1000_0000, 32'h7000_0000, 32'h9000_0000);
      add_random(100);

      wait_idle();
      repeat (150) @(posedge clock);
      $display("checked %0d result items over %0d register settings, %0d of them in band",
               checked, phases_run + 1, in_band_seen);
      if (mismatches == 0 && force_queue.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d result items outstanding", force_queue.size());
      $display("TB_ERROR");
      $finish;
   end

endmodule
